// ===== src/tpc_pkg.sv =====
// Shared types, constants and the page register encoding for the pen-tablet controller.
// Used by every module of the block; depends on nothing.
package tpc_pkg;

    typedef enum logic [1:0] {
        CMD_SAMPLE   = 2'd0,
        CMD_READ     = 2'd1,
        CMD_SET_PAGE = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [7:0]         button_bits;
        logic signed [11:0] pen_x;
        logic signed [11:0] pen_y;
        logic [23:0]        bus_address;
        logic [7:0]         new_page;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bad_address;
        logic [2:0] page_number;
    } result_t;

    localparam int PAGE_COUNT_DEFAULT = 8;

    localparam logic [23:0] ADDR_MASK  = 24'hFFFFF1;
    localparam logic [23:0] ADDR_MATCH = 24'h800001;

    localparam logic [3:0] PORT_BUTTONS = 4'h3;
    localparam logic [3:0] PORT_X_HIGH  = 4'h5;
    localparam logic [3:0] PORT_X_LOW   = 4'h7;
    localparam logic [3:0] PORT_Y_HIGH  = 4'h9;
    localparam logic [3:0] PORT_Y_LOW   = 4'hB;
    localparam logic [3:0] PORT_PAGE    = 4'hD;

    localparam logic [7:0] BUTTON_FORCE   = 8'h60;
    localparam int         PAGE_DOWN_BIT  = 5;
    localparam int         PAGE_UP_BIT    = 6;
    localparam logic [7:0] BUTTONS_IDLE   = 8'hFF;

    localparam logic [8:0]  X_OFFSET      = 9'h03C;
    localparam logic [12:0] DIV5_MULT     = 13'd6554;
    localparam int          DIV5_SHIFT    = 15;
    localparam logic [10:0] Y_BAND        = 11'd240;
    localparam logic [11:0] Y_LOW_OFFSET  = 12'h1FC;
    localparam logic [11:0] Y_HIGH_OFFSET = 12'h2F8;

    function automatic logic [7:0] page_therm(input logic [2:0] page);
        logic [7:0] code;
        case (page)
            3'd0:    code = 8'h00;
            3'd1:    code = 8'h01;
            3'd2:    code = 8'h03;
            3'd3:    code = 8'h07;
            3'd4:    code = 8'h0F;
            3'd5:    code = 8'h1F;
            default: code = 8'h3F;
        endcase
        return code;
    endfunction

endpackage

// ===== src/tpc_scale.sv =====
// Pen position scaling: x divided by five plus an offset, y moved into two bands.
// Depends on tpc_pkg.
module tpc_scale (
    input  logic signed [11:0] pen_x,
    input  logic signed [11:0] pen_y,
    output logic [8:0]         scaled_x,
    output logic [11:0]        scaled_y
);

    logic        offscreen;
    logic [10:0] x_mag;
    logic [10:0] y_mag;
    logic [23:0] x_prod;
    logic [8:0]  x_quot;

    assign offscreen = pen_x[11] | pen_y[11];
    assign x_mag     = pen_x[10:0];
    assign y_mag     = pen_y[10:0];

    // Multiplication by the reciprocal of five is exact over the whole non-negative range.
    assign x_prod = 24'(x_mag) * 24'(tpc_pkg::DIV5_MULT);
    assign x_quot = x_prod[tpc_pkg::DIV5_SHIFT +: 9];

    always_comb
    begin
        if (offscreen)
        begin
            scaled_x = '0;
            scaled_y = '0;
        end
        else
        begin
            scaled_x = x_quot + tpc_pkg::X_OFFSET;
            if (y_mag < tpc_pkg::Y_BAND)
            begin
                scaled_y = 12'(y_mag) + tpc_pkg::Y_LOW_OFFSET;
            end
            else
            begin
                scaled_y = 12'(y_mag) - 12'(tpc_pkg::Y_BAND) + tpc_pkg::Y_HIGH_OFFSET;
            end
        end
    end

endmodule

// ===== src/tpc_core.sv =====
// Controller state, page stepping and bus address decode for one transaction.
// Depends on tpc_pkg and tpc_scale.
module tpc_core #(
    parameter int PAGE_COUNT = tpc_pkg::PAGE_COUNT_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  tpc_pkg::item_t   item,
    output tpc_pkg::result_t result
);

    logic [7:0]  button_latch_reg;
    logic [7:0]  button_latch_next;
    logic [7:0]  prev_buttons_reg;
    logic [7:0]  prev_buttons_next;
    logic [2:0]  page_reg;
    logic [2:0]  page_next;
    logic [8:0]  scaled_x_reg;
    logic [8:0]  scaled_x_next;
    logic [11:0] scaled_y_reg;
    logic [11:0] scaled_y_next;

    logic [8:0]  sample_x;
    logic [11:0] sample_y;
    logic [2:0]  page_stepped;
    logic [2:0]  page_sample;
    logic        down_edge;
    logic        up_edge;
    logic        addr_match;
    logic [7:0]  read_byte;
    logic        read_ok;

    tpc_scale u_scale (
        .pen_x    (item.pen_x),
        .pen_y    (item.pen_y),
        .scaled_x (sample_x),
        .scaled_y (sample_y)
    );

    assign down_edge = prev_buttons_reg[tpc_pkg::PAGE_DOWN_BIT]
                     & ~item.button_bits[tpc_pkg::PAGE_DOWN_BIT];
    assign up_edge   = prev_buttons_reg[tpc_pkg::PAGE_UP_BIT]
                     & ~item.button_bits[tpc_pkg::PAGE_UP_BIT];

    assign page_stepped = (down_edge && page_reg < 3'(PAGE_COUNT - 1)) ? page_reg + 3'd1
                                                                       : page_reg;
    assign page_sample  = (up_edge && page_stepped != 3'd0) ? page_stepped - 3'd1
                                                            : page_stepped;

    assign addr_match = (item.bus_address & tpc_pkg::ADDR_MASK) == tpc_pkg::ADDR_MATCH;

    always_comb
    begin
        read_byte = '0;
        read_ok   = 1'b0;
        if (addr_match)
        begin
            read_ok = 1'b1;
            unique case (item.bus_address[3:0])
                tpc_pkg::PORT_BUTTONS: read_byte = button_latch_reg;
                tpc_pkg::PORT_X_HIGH:  read_byte = 8'(scaled_x_reg[8]);
                tpc_pkg::PORT_X_LOW:   read_byte = scaled_x_reg[7:0];
                tpc_pkg::PORT_Y_HIGH:  read_byte = 8'(scaled_y_reg[11:8]);
                tpc_pkg::PORT_Y_LOW:   read_byte = scaled_y_reg[7:0];
                tpc_pkg::PORT_PAGE:    read_byte = tpc_pkg::page_therm(page_reg);
                default:               read_ok   = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        button_latch_next = button_latch_reg;
        prev_buttons_next = prev_buttons_reg;
        page_next         = page_reg;
        scaled_x_next     = scaled_x_reg;
        scaled_y_next     = scaled_y_reg;
        result.read_data   = '0;
        result.bad_address = 1'b0;
        unique case (item.cmd)
            tpc_pkg::CMD_SAMPLE:
            begin
                button_latch_next = item.button_bits | tpc_pkg::BUTTON_FORCE;
                prev_buttons_next = item.button_bits;
                page_next         = page_sample;
                scaled_x_next     = sample_x;
                scaled_y_next     = sample_y;
            end
            tpc_pkg::CMD_READ:
            begin
                result.read_data   = read_byte;
                result.bad_address = ~read_ok;
            end
            tpc_pkg::CMD_SET_PAGE:
            begin
                if (item.new_page < 8'(PAGE_COUNT))
                begin
                    page_next = item.new_page[2:0];
                end
            end
            default:
            begin
            end
        endcase
        result.page_number = page_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_latch_reg <= '0;
            prev_buttons_reg <= tpc_pkg::BUTTONS_IDLE;
            page_reg         <= '0;
            scaled_x_reg     <= '0;
            scaled_y_reg     <= '0;
        end
        else if (advance)
        begin
            button_latch_reg <= button_latch_next;
            prev_buttons_reg <= prev_buttons_next;
            page_reg         <= page_next;
            scaled_x_reg     <= scaled_x_next;
            scaled_y_reg     <= scaled_y_next;
        end
    end

endmodule

// ===== src/pen_tablet_controller_io_top.sv =====
// Pen-tablet controller top level: input register, controller core and result register.
// A transaction passes the input register, then the result register; low out_ready can stall it.
// Throughput is one transaction per cycle; the input register refills while the result is taken.
// Reset clears the valid flags, buttons latch to 0x00, previous buttons to 0xFF, page to 0.
// Depends on tpc_pkg and tpc_core.
module pen_tablet_controller_io_top #(
    parameter int PAGE_COUNT = tpc_pkg::PAGE_COUNT_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [7:0]         button_bits,
    input  logic signed [11:0] pen_x,
    input  logic signed [11:0] pen_y,
    input  logic [23:0]        bus_address,
    input  logic [7:0]         new_page,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_data,
    output logic               bad_address,
    output logic [2:0]         page_number
);

    tpc_pkg::item_t   item_reg;
    tpc_pkg::item_t   item_next;
    logic             item_valid_reg;
    logic             item_valid_next;
    tpc_pkg::result_t result_reg;
    tpc_pkg::result_t result_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             advance;
    logic             in_fire;

    assign advance  = item_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~item_valid_reg | advance;
    assign in_fire  = in_valid & in_ready;

    always_comb
    begin
        item_next.cmd         = tpc_pkg::cmd_t'(cmd);
        item_next.button_bits = button_bits;
        item_next.pen_x       = pen_x;
        item_next.pen_y       = pen_y;
        item_next.bus_address = bus_address;
        item_next.new_page    = new_page;
    end

    assign item_valid_next = in_fire | (item_valid_reg & ~advance);
    assign out_valid_next  = advance | (out_valid_reg & ~out_ready);

    tpc_core #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = result_reg.read_data;
    assign bad_address = result_reg.bad_address;
    assign page_number = result_reg.page_number;

    a_page_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(page_number) < PAGE_COUNT))
        else $error("page number beyond the page count");

    a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_address) |-> (read_data == 8'h00))
        else $error("flagged read returned data");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled while the pipeline could move");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_reg)))
        else $error("pending result changed before being taken");

endmodule
